### hw/rtl/tchs_pkg.sv
// Package for the TCP connection handshake block: request, result and
// configuration types, register indexes and connection state codes.
// No dependencies.
`timescale 1ns / 1ps

package tchs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STATE_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_ADDR         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_PORT         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEND_SEQ    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RECV_WINDOW = 3'd6;

    localparam logic [STATE_W-1:0] ST_CLOSED   = 3'd0;
    localparam logic [STATE_W-1:0] ST_LISTEN   = 3'd1;
    localparam logic [STATE_W-1:0] ST_SYN_SENT = 3'd2;
    localparam logic [STATE_W-1:0] ST_SYN_RCVD = 3'd3;
    localparam logic [STATE_W-1:0] ST_ESTAB    = 3'd4;

    localparam logic REQ_SEGMENT = 1'b0;
    localparam logic REQ_OPEN    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] seg_src_addr;
        logic [31:0] seg_dst_addr;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dst_port;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_window;
        logic        seg_syn;
        logic        seg_ackflag;
        logic        seg_rst;
        logic [15:0] payload_len;
    } req_t;

    typedef struct packed {
        logic               send_valid;
        logic               tx_syn;
        logic               tx_ackflag;
        logic [31:0]        tx_seq;
        logic [31:0]        tx_ack;
        logic [15:0]        tx_window;
        logic [15:0]        tx_src_port;
        logic [15:0]        tx_dst_port;
        logic [STATE_W-1:0] conn_state;
        logic               payload_accepted;
    } rsp_t;

    typedef struct packed {
        logic        passive_mode;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] initial_send_seq;
        logic [15:0] initial_recv_window;
    } cfg_t;

endpackage

### hw/rtl/tchs_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on tchs_pkg.
`timescale 1ns / 1ps

interface tchs_req_if import tchs_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tchs_rsp_if import tchs_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/tchs_cfg_regs.sv
// Configuration register file of the TCP connection handshake block.
// Depends on tchs_pkg.
`timescale 1ns / 1ps

module tchs_cfg_regs import tchs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PASSIVE_MODE:        cfg_next.passive_mode        = cfg_wdata[0];
                CFG_LOCAL_ADDR:          cfg_next.local_addr          = cfg_wdata;
                CFG_REMOTE_ADDR:         cfg_next.remote_addr         = cfg_wdata;
                CFG_LOCAL_PORT:          cfg_next.local_port          = cfg_wdata[15:0];
                CFG_REMOTE_PORT:         cfg_next.remote_port         = cfg_wdata[15:0];
                CFG_INITIAL_SEND_SEQ:    cfg_next.initial_send_seq    = cfg_wdata;
                CFG_INITIAL_RECV_WINDOW: cfg_next.initial_recv_window = cfg_wdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/tchs_core.sv
// Connection state machine: holds the sequence pointers and state code and
// forms the result of each accepted request. Depends on tchs_pkg.
`timescale 1ns / 1ps

module tchs_core import tchs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic req_fire,
    input  req_t req,
    output rsp_t rsp
);

    logic [STATE_W-1:0] state_reg, state_next;
    logic [31:0]        send_next_reg, send_next_next;
    logic [31:0]        send_una_reg, send_una_next;
    logic [31:0]        recv_next_reg, recv_next_next;
    logic [15:0]        recv_win_reg, recv_win_next;

    logic [31:0] iss1;
    logic        addr_match;
    logic        hs_ack_ok;
    logic        accepted;

    assign iss1 = cfg.initial_send_seq + 32'd1;
    assign addr_match = (req.seg_src_addr == cfg.remote_addr) &&
                        (req.seg_dst_addr == cfg.local_addr) &&
                        (req.seg_src_port == cfg.remote_port) &&
                        (req.seg_dst_port == cfg.local_port);
    assign hs_ack_ok = (req.seg_ack == send_next_reg) && (req.seg_ack == iss1);

    always_comb
    begin
        state_next     = state_reg;
        send_next_next = send_next_reg;
        send_una_next  = send_una_reg;
        recv_next_next = recv_next_reg;
        recv_win_next  = recv_win_reg;
        accepted       = 1'b0;
        rsp            = '0;

        if (req.req_type == REQ_OPEN)
        begin
            if (state_reg == ST_CLOSED || state_reg > ST_ESTAB)
            begin
                recv_win_next = cfg.initial_recv_window;
                if (cfg.passive_mode)
                begin
                    state_next = ST_LISTEN;
                end
                else
                begin
                    send_una_next   = cfg.initial_send_seq;
                    send_next_next  = iss1;
                    rsp.send_valid  = 1'b1;
                    rsp.tx_syn      = 1'b1;
                    rsp.tx_seq      = cfg.initial_send_seq;
                    state_next      = ST_SYN_SENT;
                end
            end
        end
        else if (addr_match)
        begin
            case (state_reg)
                ST_LISTEN:
                begin
                    if (req.seg_syn)
                    begin
                        recv_next_next = req.seg_seq + 32'd1;
                        recv_win_next  = req.seg_window;
                        send_una_next  = cfg.initial_send_seq;
                        send_next_next = iss1;
                        rsp.send_valid = 1'b1;
                        rsp.tx_syn     = 1'b1;
                        rsp.tx_ackflag = 1'b1;
                        rsp.tx_seq     = cfg.initial_send_seq;
                        rsp.tx_ack     = recv_next_next;
                        state_next     = ST_SYN_RCVD;
                    end
                end
                ST_SYN_SENT:
                begin
                    if (req.seg_syn && req.seg_ackflag && hs_ack_ok)
                    begin
                        recv_next_next = req.seg_seq + 32'd1;
                        recv_win_next  = req.seg_window;
                        send_una_next  = req.seg_ack;
                        rsp.send_valid = 1'b1;
                        rsp.tx_ackflag = 1'b1;
                        rsp.tx_seq     = send_next_reg;
                        rsp.tx_ack     = recv_next_next;
                        state_next     = ST_ESTAB;
                    end
                end
                ST_SYN_RCVD:
                begin
                    if (req.seg_ackflag && hs_ack_ok)
                    begin
                        send_una_next = req.seg_ack;
                        state_next    = ST_ESTAB;
                    end
                end
                ST_ESTAB:
                begin
                    if (!req.seg_rst && !req.seg_syn && req.seg_ackflag)
                    begin
                        // plain unsigned window check, no wraparound
                        if (req.seg_ack >= send_una_reg && req.seg_ack <= send_next_reg)
                            send_una_next = req.seg_ack;
                        if (req.payload_len != 16'd0 && req.seg_seq == recv_next_reg)
                        begin
                            recv_next_next = recv_next_reg + {16'd0, req.payload_len};
                            accepted       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // closed (or an unused code): drop the segment
                    state_next = ST_CLOSED;
                end
            endcase
        end
        else if (state_reg > ST_ESTAB)
        begin
            state_next = ST_CLOSED;
        end

        if (rsp.send_valid)
        begin
            rsp.tx_window   = recv_win_next;
            rsp.tx_src_port = cfg.local_port;
            rsp.tx_dst_port = cfg.remote_port;
        end
        rsp.conn_state       = state_next;
        rsp.payload_accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLOSED;
            send_next_reg <= '0;
            send_una_reg  <= '0;
            recv_next_reg <= '0;
            recv_win_reg  <= '0;
        end
        else if (req_fire)
        begin
            state_reg     <= state_next;
            send_next_reg <= send_next_next;
            send_una_reg  <= send_una_next;
            recv_next_reg <= recv_next_next;
            recv_win_reg  <= recv_win_next;
        end
    end

endmodule

### hw/rtl/tchs_rsp_buf.sv
// Two-entry result buffer: registers each result and keeps accepting
// requests while one result waits on a stalled receiver. Depends on tchs_pkg.
`timescale 1ns / 1ps

module tchs_rsp_buf import tchs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  rsp_t wr_data,
    output logic not_full,
    tchs_rsp_if.source rsp_ch
);

    rsp_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign rd_en          = rsp_ch.valid && rsp_ch.ready;
    assign rsp_ch.valid   = (count_reg != 2'd0);
    assign rsp_ch.payload = entry_reg[rd_ptr_reg];
    assign not_full       = (count_reg != 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/tcp_connection_handshake_fsm_top.sv
// Top level of the TCP connection handshake block.
// Depends on tchs_pkg, tchs_if, tchs_cfg_regs, tchs_core, tchs_rsp_buf.
//
// Usage:
//   req_ch carries one request per handshake: an open request or a received
//   segment header. rsp_ch returns exactly one result per request: an
//   optional SYN / SYN-ACK / ACK header, the connection state after the
//   request and the in-order payload flag.
//   cfg_we / cfg_index / cfg_wdata write the connection registers; write
//   them only while no request is outstanding.
// Results: each is registered and shown after any earlier one is taken.
// Throughput: one request per cycle unless the buffer is full; the state
//   update and header build are a single pass of compares and 32-bit adds
//   between the state registers and the two-entry result buffer.
// Reset: connection goes CLOSED, all pointers and registers clear, result
//   buffer empties.
// Stall: while rsp_ch.ready is low the buffer holds up to two results;
//   req_ch.ready drops only when both entries are full.
`timescale 1ns / 1ps

module tcp_connection_handshake_fsm_top import tchs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tchs_req_if.sink              req_ch,
    tchs_rsp_if.source            rsp_ch
);

    cfg_t cfg;
    rsp_t rsp;
    logic req_fire;
    logic buf_not_full;

    assign req_ch.ready = buf_not_full;
    assign req_fire     = req_ch.valid && buf_not_full;

    tchs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tchs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req_fire (req_fire),
        .req      (req_ch.payload),
        .rsp      (rsp)
    );

    tchs_rsp_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (req_fire),
        .wr_data  (rsp),
        .not_full (buf_not_full),
        .rsp_ch   (rsp_ch)
    );

endmodule
